@@ sv/mpfd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package mpfd_pkg;

  localparam int unsigned DUR_W = 15;
  localparam int unsigned FRAME_W = 32;
  localparam int unsigned POS_W = 6;
  localparam int unsigned CFG_IDX_W = 2;

  localparam int unsigned DATA_BITS_DEFAULT = 32;

  localparam logic [DUR_W-1:0] NOISE_LIMIT_RST = DUR_W'(100);
  localparam logic [DUR_W-1:0] SINGLE_HALF_MIN_RST = DUR_W'(300);
  localparam logic [DUR_W-1:0] DOUBLE_HALF_MIN_RST = DUR_W'(700);
  localparam logic [DUR_W-1:0] DOUBLE_HALF_MAX_RST = DUR_W'(1300);

  typedef enum logic [2:0] {
    ST_OK            = 3'd0,
    ST_NO_TRANSITION = 3'd1,
    ST_BAD_START     = 3'd2,
    ST_BAD_STOP      = 3'd3,
    ST_BAD_DURATION  = 3'd4,
    ST_INCOMPLETE    = 3'd5,
    ST_PARITY        = 3'd6
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NOISE_LIMIT     = 2'd0,
    REG_SINGLE_HALF_MIN = 2'd1,
    REG_DOUBLE_HALF_MIN = 2'd2,
    REG_DOUBLE_HALF_MAX = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic             level_a;
    logic [DUR_W-1:0] duration_a;
    logic             level_b;
    logic [DUR_W-1:0] duration_b;
    logic             first_symbol;
    logic             last_symbol;
  } sym_t;

  typedef struct packed {
    logic [FRAME_W-1:0] frame_word;
    logic [2:0]         status;
    logic [POS_W-1:0]   bit_position;
  } res_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [DUR_W-1:0]     data;
  } cfg_wr_t;

endpackage

`default_nettype wire

@@ sv/mpfd_stream_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface mpfd_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ sv/manchester_pulse_frame_decoder.sv @@
`timescale 1ns / 1ps
`default_nettype none

// channel | dir | payload                                  | moves on
// --------+-----+------------------------------------------+---------------------
// sym     | in  | level_a, duration_a, level_b, duration_b, | valid & ready
//         |     | first_symbol, last_symbol                 |
// res     | out | frame_word, status, bit_position          | valid & ready
// cfg     | in  | index, data (15-bit register write)       | valid (ready is 1)
//
// one item per cycle unless stalled: an accepted item sits in the input register,
// where both of its parts (up to four half-bit steps) are decoded and the
// decoder state is updated; a last_symbol item loads the result register.
// sync reset restores register defaults and clears the decoder and both stages.
// a held result stalls only a last_symbol item; other items keep flowing.

module manchester_pulse_frame_decoder #(
  parameter int unsigned DATA_BITS = mpfd_pkg::DATA_BITS_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  mpfd_stream_if.sink   sym,
  mpfd_stream_if.source res,
  mpfd_stream_if.sink   cfg
);
  import mpfd_pkg::*;

  localparam int unsigned STOP_INDEX = DATA_BITS + 1;
  localparam int unsigned END_INDEX = DATA_BITS + 2;
  localparam int unsigned CNT_W = $clog2(END_INDEX + 1);
  localparam int unsigned EXT_W = (DATA_BITS > FRAME_W) ? DATA_BITS : FRAME_W;
  localparam int unsigned POS_EXT_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef struct packed {
    logic [DATA_BITS-1:0] word;
    logic [CNT_W-1:0]     cnt;
    logic                 await;
    logic                 hi;
    status_t              err;
  } dec_t;

  logic [DUR_W-1:0] noise_limit;
  logic [DUR_W-1:0] single_half_min;
  logic [DUR_W-1:0] double_half_min;
  logic [DUR_W-1:0] double_half_max;

  sym_t sym_q;
  logic sym_vld;
  res_t res_q;
  logic res_vld;
  dec_t dec;
  dec_t dec_next;
  res_t res_next;
  logic advance;

  function automatic logic dec_active(dec_t s);
    return (s.err == ST_OK) && (s.cnt < CNT_W'(END_INDEX));
  endfunction

  function automatic dec_t take_half(dec_t s, logic level);
    dec_t r;
    logic b;
    r = s;
    b = s.hi & ~level;
    if (dec_active(s)) begin
      if (!s.await) begin
        r.hi = level;
        r.await = 1'b1;
      end else if (s.hi == level) begin
        r.err = ST_NO_TRANSITION;
      end else if (s.cnt == '0 && !b) begin
        r.err = ST_BAD_START;
      end else if (s.cnt == CNT_W'(STOP_INDEX) && !b) begin
        r.err = ST_BAD_STOP;
      end else begin
        if (s.cnt <= CNT_W'(DATA_BITS)) begin
          r.word = {s.word[DATA_BITS-2:0], b};
        end
        r.cnt = s.cnt + CNT_W'(1);
        r.await = 1'b0;
      end
    end
    return r;
  endfunction

  function automatic dec_t take_part(dec_t s, logic level, logic [DUR_W-1:0] dur,
                                     logic [DUR_W-1:0] nlim, logic [DUR_W-1:0] smin,
                                     logic [DUR_W-1:0] dmin, logic [DUR_W-1:0] dmax);
    dec_t r;
    r = s;
    if (dec_active(s) && dur != '0 && dur >= nlim) begin
      if (dur >= smin && dur < dmin) begin
        r = take_half(s, level);
      end else if (dur >= dmin && dur <= dmax) begin
        r = take_half(take_half(s, level), level);
      end else begin
        r.err = ST_BAD_DURATION;
      end
    end
    return r;
  endfunction

  // a held result only blocks an item that would produce another one
  assign advance = sym_vld && (!sym_q.last_symbol || !res_vld || res.ready);
  assign sym.ready = !sym_vld || advance;
  assign cfg.ready = 1'b1;
  assign res.valid = res_vld;
  assign res.data = res_q;

  always_comb begin
    dec_t s;
    logic [CNT_W-1:0] pos;
    status_t st;
    logic [EXT_W-1:0] frame_ext;
    logic [POS_EXT_W-1:0] pos_ext;

    s = dec;
    if (sym_q.first_symbol) begin
      s = '{word: '0, cnt: '0, await: 1'b0, hi: 1'b0, err: ST_OK};
      // idle high merged with the start bit's high half
      if (sym_q.level_a && sym_q.duration_a != '0 && !sym_q.level_b &&
          sym_q.duration_b != '0) begin
        s.hi = 1'b1;
        s.await = 1'b1;
      end else begin
        s = take_part(s, sym_q.level_a, sym_q.duration_a, noise_limit,
                      single_half_min, double_half_min, double_half_max);
      end
    end else begin
      s = take_part(s, sym_q.level_a, sym_q.duration_a, noise_limit,
                    single_half_min, double_half_min, double_half_max);
    end
    s = take_part(s, sym_q.level_b, sym_q.duration_b, noise_limit,
                  single_half_min, double_half_min, double_half_max);
    dec_next = s;

    st = s.err;
    pos = s.cnt;
    // stop bit's trailing low half is often lost at the end of a capture
    if (st == ST_OK && pos == CNT_W'(STOP_INDEX) && s.await && s.hi) begin
      pos = pos + CNT_W'(1);
    end
    if (st == ST_OK && pos != CNT_W'(END_INDEX)) begin
      st = ST_INCOMPLETE;
    end
    if (st == ST_OK && (^s.word)) begin
      st = ST_PARITY;
    end
    frame_ext = (st == ST_OK) ? EXT_W'(s.word) : '0;
    pos_ext = POS_EXT_W'(pos);
    res_next.frame_word = frame_ext[FRAME_W-1:0];
    res_next.status = st;
    res_next.bit_position = pos_ext[POS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      noise_limit <= NOISE_LIMIT_RST;
      single_half_min <= SINGLE_HALF_MIN_RST;
      double_half_min <= DOUBLE_HALF_MIN_RST;
      double_half_max <= DOUBLE_HALF_MAX_RST;
    end else if (cfg.valid) begin
      case (cfg.data.index)
        REG_NOISE_LIMIT:     noise_limit <= cfg.data.data;
        REG_SINGLE_HALF_MIN: single_half_min <= cfg.data.data;
        REG_DOUBLE_HALF_MIN: double_half_min <= cfg.data.data;
        REG_DOUBLE_HALF_MAX: double_half_max <= cfg.data.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sym_vld <= 1'b0;
      res_vld <= 1'b0;
      dec <= '{word: '0, cnt: '0, await: 1'b0, hi: 1'b0, err: ST_OK};
    end else begin
      if (sym.ready) begin
        sym_vld <= sym.valid;
      end
      if (advance) begin
        dec <= dec_next;
      end
      if (advance && sym_q.last_symbol) begin
        res_vld <= 1'b1;
      end else if (res.ready) begin
        res_vld <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sym.ready && sym.valid) begin
      sym_q <= sym.data;
    end
    if (advance && sym_q.last_symbol) begin
      res_q <= res_next;
    end
  end

`ifndef ASSERT_OFF
  a_ok_full_frame: assert property (@(posedge clk) disable iff (rst)
    res_vld && res_q.status == ST_OK |-> res_q.bit_position == POS_W'(END_INDEX))
    else $error("ok result without a full frame");

  a_err_zero_frame: assert property (@(posedge clk) disable iff (rst)
    res_vld && res_q.status != ST_OK |-> res_q.frame_word == '0)
    else $error("error result carries frame data");

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    dec.cnt <= CNT_W'(END_INDEX))
    else $error("bit count beyond frame end");

  a_res_from_last: assert property (@(posedge clk) disable iff (rst)
    $rose(res_vld) |-> $past(advance && sym_q.last_symbol))
    else $error("result without a last symbol");
`endif

endmodule

`default_nettype wire

@@ test/manchester_pulse_frame_decoder_tb.sv @@
`timescale 1ns / 1ps

module manchester_pulse_frame_decoder_tb;
  import mpfd_pkg::*;

  localparam int unsigned DATA_BITS = DATA_BITS_DEFAULT;
  localparam int unsigned STOP_POS = DATA_BITS + 1;
  localparam int unsigned END_POS = DATA_BITS + 2;
  localparam int unsigned ITEMS_PER_PHASE = 155;
  localparam int unsigned CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic             lvl;
    logic [DUR_W-1:0] dur;
  } line_part_t;

  class frame_scoreboard;
    logic [DUR_W-1:0]   noise_lim, single_min, double_min, double_max;
    logic [FRAME_W-1:0] shift_word;
    int unsigned        bit_cnt;
    bit                 awaiting, first_high;
    status_t            err;
    res_t               expected_frames[$];
    int                 errors;

    function new();
      noise_lim = NOISE_LIMIT_RST;
      single_min = SINGLE_HALF_MIN_RST;
      double_min = DOUBLE_HALF_MIN_RST;
      double_max = DOUBLE_HALF_MAX_RST;
      errors = 0;
      clear();
    endfunction

    function void clear();
      shift_word = '0;
      bit_cnt = 0;
      awaiting = 0;
      first_high = 0;
      err = ST_OK;
    endfunction

    function void set_reg(cfg_reg_t idx, logic [DUR_W-1:0] v);
      case (idx)
        REG_NOISE_LIMIT:     noise_lim = v;
        REG_SINGLE_HALF_MIN: single_min = v;
        REG_DOUBLE_HALF_MIN: double_min = v;
        REG_DOUBLE_HALF_MAX: double_max = v;
        default: ;
      endcase
    endfunction

    function bit active();
      return err == ST_OK && bit_cnt < END_POS;
    endfunction

    function void take_half(bit lvl);
      bit b;
      if (!active()) return;
      if (!awaiting) begin
        first_high = lvl;
        awaiting = 1;
        return;
      end
      if (first_high == lvl) begin
        err = ST_NO_TRANSITION;
        return;
      end
      b = first_high && !lvl;
      if (bit_cnt == 0 && !b) begin
        err = ST_BAD_START;
      end else if (bit_cnt == STOP_POS && !b) begin
        err = ST_BAD_STOP;
      end else begin
        if (bit_cnt <= DATA_BITS) shift_word = {shift_word[FRAME_W-2:0], b};
        bit_cnt++;
        awaiting = 0;
      end
    endfunction

    function void take_part(bit lvl, logic [DUR_W-1:0] d);
      if (!active()) return;
      if (d == 0 || d < noise_lim) return;
      if (d >= single_min && d < double_min) begin
        take_half(lvl);
      end else if (d >= double_min && d <= double_max) begin
        take_half(lvl);
        take_half(lvl);
      end else begin
        err = ST_BAD_DURATION;
      end
    endfunction

    // decode one accepted symbol, queue the frame result on a last symbol
    function void decode_symbol(sym_t s);
      res_t        r;
      status_t     st;
      int unsigned pos;
      if (s.first_symbol) begin
        clear();
        // idle merged with the start high half
        if (s.level_a && s.duration_a > 0 && !s.level_b && s.duration_b > 0) begin
          first_high = 1;
          awaiting = 1;
        end else begin
          take_part(s.level_a, s.duration_a);
        end
      end else begin
        take_part(s.level_a, s.duration_a);
      end
      take_part(s.level_b, s.duration_b);
      if (!s.last_symbol) return;
      st = err;
      pos = bit_cnt;
      // stop bit low half missing at the end of the capture
      if (st == ST_OK && pos == STOP_POS && awaiting && first_high) pos++;
      if (st == ST_OK && pos != END_POS) st = ST_INCOMPLETE;
      if (st == ST_OK && ^shift_word) st = ST_PARITY;
      r.frame_word = (st == ST_OK) ? shift_word : '0;
      r.status = st;
      r.bit_position = pos[POS_W-1:0];
      expected_frames.push_back(r);
    endfunction

    task report(string field, logic [31:0] got, logic [31:0] want);
      errors++;
      $display("%0t mismatch %s: got %0h, expected %0h", $time, field, got, want);
    endtask

    task check_frame(res_t got);
      res_t want;
      if (expected_frames.size() == 0) begin
        report("result with none pending", got.frame_word, 0);
        return;
      end
      want = expected_frames.pop_front();
      if (got.frame_word !== want.frame_word)
        report("frame_word", got.frame_word, want.frame_word);
      if (got.status !== want.status) report("status", got.status, want.status);
      if (got.bit_position !== want.bit_position)
        report("bit_position", got.bit_position, want.bit_position);
    endtask
  endclass

  logic clk;
  logic rst;

  mpfd_stream_if #(.T(sym_t))    sym_if ();
  mpfd_stream_if #(.T(res_t))    res_if ();
  mpfd_stream_if #(.T(cfg_wr_t)) cfg_if ();

  manchester_pulse_frame_decoder dut (
    .clk (clk),
    .rst (rst),
    .sym (sym_if),
    .res (res_if),
    .cfg (cfg_if)
  );

  frame_scoreboard sb = new();
  int unsigned     n_sent = 0;
  int unsigned     cycles = 0;
  int              hold_left = 0;
  bit              no_gaps = 0;

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  // result side: handshake settles by the falling edge, the item moves at the next rising one
  initial begin
    bit   take;
    res_t got;
    res_if.ready <= 1'b0;
    forever begin
      @(negedge clk);
      take = !rst && res_if.valid && res_if.ready;
      got = res_if.data;
      @(posedge clk);
      if (take) sb.check_frame(got);
      if (hold_left > 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= no_gaps || ($urandom_range(99) >= 34);
      end
    end
  end

  function automatic logic [DUR_W-1:0] pick_in(int lo, int hi);
    int r;
    if (lo > hi) return DUR_W'($urandom_range(32767, 0));
    r = $urandom_range(9);
    if (r == 0) return DUR_W'(lo);
    if (r == 1) return DUR_W'(hi);
    return DUR_W'($urandom_range(hi, lo));
  endfunction

  function automatic sym_t mk(bit la, logic [DUR_W-1:0] da, bit lb, logic [DUR_W-1:0] db,
                              bit f, bit l);
    sym_t s;
    s.level_a = la;
    s.duration_a = da;
    s.level_b = lb;
    s.duration_b = db;
    s.first_symbol = f;
    s.last_symbol = l;
    return s;
  endfunction

  function automatic sym_t rand_sym(bit force_last);
    sym_t s;
    s = sym_t'(34'({$urandom, $urandom}));
    if ($urandom_range(1)) s.duration_a = DUR_W'($urandom_range(2000));
    if ($urandom_range(1)) s.duration_b = DUR_W'($urandom_range(2000));
    s.first_symbol = ($urandom_range(4) == 0) || force_last;
    s.last_symbol = ($urandom_range(3) == 0) || force_last;
    return s;
  endfunction

  task automatic send_symbol(sym_t s);
    bit acc;
    while (!no_gaps && $urandom_range(99) < 34) begin
      sym_if.valid <= 1'b0;
      @(posedge clk);
    end
    sym_if.valid <= 1'b1;
    sym_if.data <= s;
    do begin
      @(negedge clk);
      acc = sym_if.ready;
      @(posedge clk);
    end while (!acc);
    sb.decode_symbol(s);
    n_sent++;
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [DUR_W-1:0] v);
    cfg_wr_t w;
    w.index = idx;
    w.data = v;
    cfg_if.valid <= 1'b1;
    cfg_if.data <= w;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    sb.set_reg(idx, v);
  endtask

  task automatic write_cfg(int n, int s1, int d1, int d2);
    write_reg(REG_NOISE_LIMIT, DUR_W'(n));
    write_reg(REG_SINGLE_HALF_MIN, DUR_W'(s1));
    write_reg(REG_DOUBLE_HALF_MIN, DUR_W'(d1));
    write_reg(REG_DOUBLE_HALF_MAX, DUR_W'(d2));
    cfg_if.valid <= 1'b0;
  endtask

  task automatic wait_idle();
    sym_if.valid <= 1'b0;
    while (sb.expected_frames.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // one capture of a frame, clean most of the time, else broken in one way
  task automatic send_frame();
    logic [FRAME_W-1:0] word;
    bit                 halves[$];
    line_part_t         parts[$];
    line_part_t         line[$];
    line_part_t         p;
    bit                 start_b, stop_b, b;
    int                 kind, n, j, len, idx, s_lo, s_hi, d_lo, d_hi;
    kind = $urandom_range(99);
    case ($urandom_range(9))
      0:       word = '0;
      1:       word = '1;
      default: word = $urandom;
    endcase
    start_b = !(kind >= 55 && kind < 60);
    stop_b = !(kind >= 60 && kind < 65);
    for (int i = 0; i < END_POS; i++) begin
      b = (i == 0) ? start_b : (i == STOP_POS) ? stop_b : word[FRAME_W - i];
      halves.push_back(b);
      halves.push_back(!b);
    end
    n = halves.size();
    if (kind >= 72 && kind < 78) n = $urandom_range(n - 1, 1);

    s_lo = (sb.single_min > sb.noise_lim) ? sb.single_min : sb.noise_lim;
    if (s_lo < 1) s_lo = 1;
    s_hi = int'(sb.double_min) - 1;
    d_lo = (sb.double_min > sb.noise_lim) ? sb.double_min : sb.noise_lim;
    if (d_lo < 1) d_lo = 1;
    d_hi = sb.double_max;

    j = 0;
    while (j < n) begin
      len = (j + 1 < n && halves[j + 1] == halves[j]) ? 2 : 1;
      p.lvl = halves[j];
      p.dur = (len == 1) ? pick_in(s_lo, s_hi) : pick_in(d_lo, d_hi);
      parts.push_back(p);
      j += len;
    end

    idx = $urandom_range(parts.size() - 1);
    if (kind >= 65 && kind < 72) begin
      void'(parts.pop_back());
    end else if (kind >= 78 && kind < 84) begin
      parts[idx].lvl = !parts[idx].lvl;
    end else if (kind >= 84 && kind < 90) begin
      parts[idx].dur = (sb.double_max < 15'h7fff) ? pick_in(int'(sb.double_max) + 1, 32767)
                                                  : pick_in(1, int'(sb.single_min) - 1);
    end else if (kind >= 90 && kind < 95) begin
      parts.delete(idx);
    end
    if (parts.size() > 0 && parts[0].lvl && $urandom_range(1))
      parts[0].dur = DUR_W'($urandom_range(32767, 1));

    foreach (parts[k]) begin
      if (k > 0 && $urandom_range(9) == 0) begin
        p.lvl = $urandom_range(1);
        p.dur = (sb.noise_lim > 1) ? pick_in(1, int'(sb.noise_lim) - 1) : '0;
        line.push_back(p);
      end
      line.push_back(parts[k]);
    end
    p.lvl = $urandom_range(1);
    p.dur = '0;
    // end marker, and padding so the parts pair up
    if ($urandom_range(2) == 0) line.push_back(p);
    if (line.size() % 2) line.push_back(p);

    for (int k = 0; k < line.size(); k += 2)
      send_symbol(mk(line[k].lvl, line[k].dur, line[k + 1].lvl, line[k + 1].dur,
                     k == 0, k + 2 >= line.size()));
  endtask

  initial begin
    int unsigned quota;
    int          n, s1, d1;
    rst <= 1'b1;
    sym_if.valid <= 1'b0;
    sym_if.data <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.data <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed items at the reset thresholds
    send_symbol(mk(1, 400, 0, 400, 1, 1));
    send_symbol(mk(0, 400, 1, 400, 1, 1));
    send_symbol(mk(0, 400, 0, 400, 1, 1));
    send_symbol(mk(1, 32767, 0, 400, 1, 1));
    send_symbol(mk(1, 32767, 1, 400, 1, 1));
    send_symbol(mk(0, 0, 0, 0, 1, 1));
    send_symbol(mk(1, 99, 0, 99, 1, 1));
    send_symbol(mk(0, 99, 1, 1300, 1, 1));
    send_symbol(mk(0, 0, 1, 300, 1, 0));
    send_symbol(mk(0, 699, 1, 700, 0, 1));
    send_symbol(mk(1, 1301, 1, 1299, 1, 1));
    send_symbol(mk(1, 32767, 1, 32767, 1, 1));
    send_symbol(mk(0, 400, 1, 400, 0, 1));
    send_symbol(mk(1, 300, 0, 699, 1, 0));
    send_symbol(mk(1, 1300, 0, 100, 0, 1));
    wait_idle();

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        1: write_cfg(0, 1, 2, 2);
        2: write_cfg(30000, 30000, 31000, 32767);
        3: begin
          n = $urandom_range(400);
          s1 = n + $urandom_range(400);
          d1 = s1 + $urandom_range(800, 1);
          write_cfg(n, s1, d1, d1 + $urandom_range(1500));
        end
        4: write_cfg(NOISE_LIMIT_RST, SINGLE_HALF_MIN_RST, DOUBLE_HALF_MIN_RST,
                     DOUBLE_HALF_MAX_RST);
        5: write_cfg($urandom_range(1) ? 32767 : $urandom_range(32767),
                     $urandom_range(32767), $urandom_range(32767), $urandom_range(32767));
        default: ;
      endcase
      no_gaps = (phase == 4);
      if (phase == 3) begin
        // results held back long enough for the input to back up
        hold_left = 400;
        repeat (24) send_symbol(rand_sym(1));
      end
      quota = n_sent + ITEMS_PER_PHASE;
      while (n_sent < quota) begin
        if ($urandom_range(99) < 80) begin
          send_frame();
        end else begin
          repeat ($urandom_range(3, 1)) send_symbol(rand_sym(0));
        end
      end
      wait_idle();
    end
    no_gaps = 0;

    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.expected_frames.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
